[sv/aapr_pkg.sv]
// shared types, constants and the cordic angle table for the axis-angle point rotator
// no dependencies
package aapr_pkg;

    localparam int unsigned CordicSteps = 30;
    localparam int unsigned StepW       = 5;
    localparam int unsigned QueueDepth  = 4;
    localparam int unsigned QueueAw     = 2;

    localparam logic signed [33:0] CordicGain  = 34'sd652032874;
    localparam logic signed [32:0] QuarterTurn = 33'sd1073741824;
    localparam logic signed [32:0] HalfTurn    = 33'sd2147483648;

    localparam logic [7:0] RegAxisX = 8'd0;
    localparam logic [7:0] RegAxisY = 8'd1;
    localparam logic [7:0] RegAxisZ = 8'd2;
    localparam logic [7:0] RegAngle = 8'd3;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } t_point;

    typedef struct packed {
        logic signed [23:0] w;
        logic signed [23:0] z;
        logic signed [23:0] y;
        logic signed [23:0] x;
    } t_quat;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ITER,
        CS_FINISH
    } t_cordic_state;

    function automatic logic signed [32:0] atan_entry(input logic [StepW-1:0] idx);
        logic signed [32:0] v;
        case (idx)
            5'd0:  v = 33'sh020000000;
            5'd1:  v = 33'sh012E4051E;
            5'd2:  v = 33'sh009FB385B;
            5'd3:  v = 33'sh0051111D4;
            5'd4:  v = 33'sh0028B0D43;
            5'd5:  v = 33'sh00145D7E1;
            5'd6:  v = 33'sh000A2F61E;
            5'd7:  v = 33'sh000517C55;
            5'd8:  v = 33'sh00028BE53;
            5'd9:  v = 33'sh000145F2F;
            5'd10: v = 33'sh0000A2F98;
            5'd11: v = 33'sh0000517CC;
            5'd12: v = 33'sh000028BE6;
            5'd13: v = 33'sh0000145F3;
            5'd14: v = 33'sh00000A2FA;
            5'd15: v = 33'sh00000517D;
            5'd16: v = 33'sh0000028BE;
            5'd17: v = 33'sh00000145F;
            5'd18: v = 33'sh000000A30;
            5'd19: v = 33'sh000000518;
            5'd20: v = 33'sh00000028C;
            5'd21: v = 33'sh000000146;
            5'd22: v = 33'sh0000000A3;
            5'd23: v = 33'sh000000051;
            5'd24: v = 33'sh000000029;
            5'd25: v = 33'sh000000014;
            5'd26: v = 33'sh00000000A;
            5'd27: v = 33'sh000000005;
            5'd28: v = 33'sh000000003;
            5'd29: v = 33'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[sv/axis_angle_point_rotator.sv]
// channel     dir  handshake                    payload
// s_axis      in   s_axis_tvalid/s_axis_tready  point x,y,z,w (4 x 32 bit)
// m_axis      out  m_axis_tvalid/m_axis_tready  rotated x,y,z,w (4 x 32 bit)
// cfg         in   i_cfg_valid/o_cfg_ready      register index, 16-bit value
//
// one point per cycle unless held or stalled; stages r_v, r_p1, r_t, r_p2, r_out
// after reset and after each axis or angle write, the cordic setup holds s_axis
// a 4-entry point queue lets the input keep flowing while m_axis stalls
// top level of the axis-angle point rotator; depends on aapr_pkg, aapr_cordic,
// aapr_front and aapr_back
module axis_angle_point_rotator import aapr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // point_x, point_y, point_z, point_w
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // rotated_x, rotated_y, rotated_z, rotated_w
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);

    logic signed [15:0] r_axis_x, r_axis_y, r_axis_z;
    logic        [15:0] r_angle;
    logic               r_kick;
    logic               w_busy, w_cfg_wr, w_pop, w_q_valid;
    t_quat              w_quat;
    t_point             w_q_data, w_m_data;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_x <= '0;
            r_axis_y <= '0;
            r_axis_z <= '0;
            r_angle  <= '0;
            r_kick   <= 1'b1;
        end else begin
            r_kick <= 1'b0;
            if (w_cfg_wr) begin
                case (i_cfg_index)
                    RegAxisX: begin r_axis_x <= i_cfg_data; r_kick <= 1'b1; end
                    RegAxisY: begin r_axis_y <= i_cfg_data; r_kick <= 1'b1; end
                    RegAxisZ: begin r_axis_z <= i_cfg_data; r_kick <= 1'b1; end
                    RegAngle: begin r_angle  <= i_cfg_data; r_kick <= 1'b1; end
                    default: ;
                endcase
            end
        end
    end

    aapr_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_kick),
        .i_axis_x (r_axis_x),
        .i_axis_y (r_axis_y),
        .i_axis_z (r_axis_z),
        .i_angle  (r_angle),
        .o_busy   (w_busy),
        .o_quat   (w_quat)
    );

    aapr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_data  (t_point'(s_axis_tdata)),
        .o_s_ready (s_axis_tready),
        .i_hold    (r_kick || w_busy),
        .i_pop     (w_pop),
        .o_q_valid (w_q_valid),
        .o_q_data  (w_q_data)
    );

    aapr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_quat    (w_quat),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_pop     (w_pop),
        .o_m_valid (m_axis_tvalid),
        .o_m_data  (w_m_data),
        .i_m_ready (m_axis_tready)
    );

    assign m_axis_tdata = 128'(w_m_data);

endmodule

[sv/aapr_cordic.sv]
// half-angle sine/cosine by iterative cordic and the rotation quaternion
// depends on aapr_pkg
module aapr_cordic import aapr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_axis_x,
    input  logic signed [15:0] i_axis_y,
    input  logic signed [15:0] i_axis_z,
    input  logic        [15:0] i_angle,
    output logic               o_busy,
    output t_quat              o_quat
);

    t_cordic_state       r_state, n_state;
    logic signed [33:0]  r_x, r_y;
    logic signed [32:0]  r_z;
    logic [StepW-1:0]    r_step;
    logic                r_flip;
    t_quat               r_quat;

    logic signed [32:0]  w_z0;
    logic signed [33:0]  w_dx, w_dy, w_cos;
    logic signed [49:0]  w_px, w_py, w_pz;
    logic signed [49:0]  w_half;

    always_comb begin
        n_state = r_state;
        case (r_state)
            CS_IDLE:   n_state = CS_IDLE;
            CS_ITER:   if (r_step == StepW'(CordicSteps - 1)) n_state = CS_FINISH;
            CS_FINISH: n_state = CS_IDLE;
            default:   n_state = CS_IDLE;
        endcase
        if (i_start) begin
            n_state = CS_ITER;
        end
    end

    always_comb begin
        case (r_state)
            CS_IDLE: o_busy = 1'b0;
            default: o_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        w_z0   = 33'({i_angle, 15'd0});
        w_dx   = r_y >>> r_step;
        w_dy   = r_x >>> r_step;
        w_cos  = r_flip ? -r_x : r_x;
        w_half = 50'sd1 <<< 23;
        w_px   = (50'(r_y) * 50'(i_axis_x) + w_half) >>> 24;
        w_py   = (50'(r_y) * 50'(i_axis_y) + w_half) >>> 24;
        w_pz   = (50'(r_y) * 50'(i_axis_z) + w_half) >>> 24;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CordicGain;
            r_y    <= '0;
            r_step <= '0;
            if (w_z0 > QuarterTurn) begin
                r_z    <= HalfTurn - w_z0;
                r_flip <= 1'b1;
            end else begin
                r_z    <= w_z0;
                r_flip <= 1'b0;
            end
        end else if (r_state == CS_ITER) begin
            r_step <= r_step + 1'b1;
            if (!r_z[32]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - atan_entry(r_step);
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + atan_entry(r_step);
            end
        end else if (r_state == CS_FINISH) begin
            r_quat.x <= 24'(w_px);
            r_quat.y <= 24'(w_py);
            r_quat.z <= 24'(w_pz);
            r_quat.w <= 24'((w_cos + 34'sd512) >>> 10);
        end
    end

    assign o_quat = r_quat;

endmodule

[sv/aapr_front.sv]
// input acceptance and the point queue feeding the arithmetic pipeline
// depends on aapr_pkg
module aapr_front import aapr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_s_valid,
    input  t_point i_s_data,
    output logic   o_s_ready,
    input  logic   i_hold,
    input  logic   i_pop,
    output logic   o_q_valid,
    output t_point o_q_data
);

    t_point             r_mem [QueueDepth];
    logic [QueueAw-1:0] r_wr, r_rd;
    logic [QueueAw:0]   r_count;
    logic               w_push, w_pop;

    assign o_s_ready = (r_count != (QueueAw+1)'(QueueDepth)) && !i_hold;
    assign w_push    = i_s_valid && o_s_ready;
    assign o_q_valid = (r_count != '0);
    assign w_pop     = i_pop && o_q_valid;
    assign o_q_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + (QueueAw+1)'(w_push) - (QueueAw+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_s_data;
        end
    end

endmodule

[sv/aapr_back.sv]
// pipelined sandwich product q*v*conj(q) with rounding and saturation
// depends on aapr_pkg
module aapr_back import aapr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_quat  i_quat,
    input  logic   i_q_valid,
    input  t_point i_q_data,
    output logic   o_pop,
    output logic   o_m_valid,
    output t_point o_m_data,
    input  logic   i_m_ready
);

    logic               w_ce;
    logic [3:0]         r_vld;
    logic               r_out_valid;
    logic signed [31:0] r_v  [4];
    logic signed [55:0] r_p1 [4][4];
    logic signed [39:0] r_t  [4];
    logic signed [63:0] r_p2 [4][4];
    t_point             r_out;

    logic signed [23:0] w_q  [4];
    logic signed [57:0] w_s1 [4];
    logic signed [65:0] w_s2 [4];
    logic signed [45:0] w_r  [4];
    logic signed [31:0] w_sat[4];

    assign w_ce  = !r_out_valid || i_m_ready;
    assign o_pop = w_ce && i_q_valid;

    always_comb begin
        w_q[0] = i_quat.x;
        w_q[1] = i_quat.y;
        w_q[2] = i_quat.z;
        w_q[3] = i_quat.w;
        // t = q*v, products indexed [point][quat]
        w_s1[0] = 58'(r_p1[0][3]) + 58'(r_p1[3][0]) + 58'(r_p1[2][1]) - 58'(r_p1[1][2]);
        w_s1[1] = 58'(r_p1[1][3]) + 58'(r_p1[3][1]) + 58'(r_p1[0][2]) - 58'(r_p1[2][0]);
        w_s1[2] = 58'(r_p1[2][3]) + 58'(r_p1[3][2]) + 58'(r_p1[1][0]) - 58'(r_p1[0][1]);
        w_s1[3] = 58'(r_p1[3][3]) - 58'(r_p1[0][0]) - 58'(r_p1[1][1]) - 58'(r_p1[2][2]);
        // r = t*conj(q), products indexed [t][quat]
        w_s2[0] = 66'(r_p2[0][3]) - 66'(r_p2[3][0]) - 66'(r_p2[1][2]) + 66'(r_p2[2][1]);
        w_s2[1] = 66'(r_p2[1][3]) - 66'(r_p2[3][1]) - 66'(r_p2[2][0]) + 66'(r_p2[0][2]);
        w_s2[2] = 66'(r_p2[2][3]) - 66'(r_p2[3][2]) - 66'(r_p2[0][1]) + 66'(r_p2[1][0]);
        w_s2[3] = 66'(r_p2[3][3]) + 66'(r_p2[0][0]) + 66'(r_p2[1][1]) + 66'(r_p2[2][2]);
        for (int k = 0; k < 4; k++) begin
            w_r[k] = 46'((w_s2[k] + (66'sd1 <<< 19)) >>> 20);
            if (w_r[k] > 46'sd2147483647) begin
                w_sat[k] = 32'sh7FFFFFFF;
            end else if (w_r[k] < -46'sd2147483648) begin
                w_sat[k] = 32'sh80000000;
            end else begin
                w_sat[k] = 32'(w_r[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_ce) begin
            r_vld       <= {r_vld[2:0], i_q_valid};
            r_out_valid <= r_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_v[0] <= i_q_data.x;
            r_v[1] <= i_q_data.y;
            r_v[2] <= i_q_data.z;
            r_v[3] <= i_q_data.w;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_p1[i][j] <= 56'(r_v[i]) * 56'(w_q[j]);
                    r_p2[i][j] <= 64'(r_t[i]) * 64'(w_q[j]);
                end
                r_t[i] <= 40'((w_s1[i] + (58'sd1 <<< 19)) >>> 20);
            end
            r_out.x <= w_sat[0];
            r_out.y <= w_sat[1];
            r_out.z <= w_sat[2];
            r_out.w <= w_sat[3];
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out;

`ifndef SYNTHESIS
    a_stall_keeps_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_ready |=> r_out_valid)
        else $error("result dropped under stall");
    a_pop_only_when_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> w_ce)
        else $error("queue popped while pipeline stalled");
    a_last_stage_feeds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ce && r_vld[3] |=> r_out_valid)
        else $error("item lost between last stage and output");
`endif

endmodule
